### src/dks_pkg.sv
package dks_pkg;

    localparam int KMER_MAX     = 16;
    localparam int SEED_REGS    = 4;
    localparam int MAX_READ_LEN = 1048576;
    localparam int HASH_W       = 32;
    localparam int POS_W        = 20;
    localparam int COUNT_W      = 21;
    localparam int KLEN_W       = 5;
    localparam int CHAR_W       = 8;
    localparam int IDX_W        = 2;
    localparam int CFG_IDX_W    = 3;

    localparam int POS_FIELD_MAX = (1 << POS_W) - 1;
    localparam int POS_LIMIT_I   = ((MAX_READ_LEN - 1) < POS_FIELD_MAX) ?
                                   (MAX_READ_LEN - 1) : POS_FIELD_MAX;
    localparam logic [COUNT_W-1:0] POS_LIMIT = COUNT_W'(POS_LIMIT_I);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_THREE = 3'd5;

    // complement of a base code: A<->T, C<->G
    localparam logic [1:0] COMPL_FLIP = 2'd2;

    typedef struct packed {
        logic [HASH_W-1:0]  kmer;
        logic [COUNT_W-1:0] count;
        logic               win;
        logic [POS_W-1:0]   pos;
    } kmer_step_t;

    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
        return c[2:1];
    endfunction

endpackage

### src/dks_kmer_roll.sv
module dks_kmer_roll (
    input  logic [dks_pkg::HASH_W-1:0]  kmer_cur,
    input  logic [dks_pkg::COUNT_W-1:0] count_cur,
    input  logic [dks_pkg::KLEN_W-1:0]  kmer_len,
    input  logic                        reverse_strand,
    input  logic [dks_pkg::CHAR_W-1:0]  base_char,
    output dks_pkg::kmer_step_t         step
);

    logic [dks_pkg::KLEN_W-1:0]  k;
    logic [5:0]                  two_k;
    logic [4:0]                  top_sh;
    logic [dks_pkg::HASH_W-1:0]  mask;
    logic [dks_pkg::HASH_W-1:0]  rolled;
    logic [1:0]                  code;
    logic [dks_pkg::COUNT_W-1:0] cnt;
    logic [dks_pkg::COUNT_W-1:0] offs;

    always_comb begin
        // clamp k into 1..16
        if (kmer_len == '0) begin
            k = dks_pkg::KLEN_W'(1);
        end else if (kmer_len > dks_pkg::KLEN_W'(dks_pkg::KMER_MAX)) begin
            k = dks_pkg::KLEN_W'(dks_pkg::KMER_MAX);
        end else begin
            k = kmer_len;
        end
        two_k  = {k, 1'b0};
        top_sh = 5'(two_k - 6'd2);
        mask   = ~({dks_pkg::HASH_W{1'b1}} << two_k);
        code   = dks_pkg::base_code(base_char);

        if (reverse_strand) begin
            rolled = (kmer_cur >> 2) +
                     ({30'd0, code ^ dks_pkg::COMPL_FLIP} << top_sh);
        end else begin
            rolled = (kmer_cur << 2) + {30'd0, code};
        end
        step.kmer = rolled & mask;

        cnt = (count_cur == dks_pkg::COUNT_MAX) ? count_cur :
              count_cur + dks_pkg::COUNT_W'(1);
        step.count = cnt;
        step.win   = (cnt >= dks_pkg::COUNT_W'(k));
        offs       = cnt - dks_pkg::COUNT_W'(k);
        step.pos   = (offs > dks_pkg::POS_LIMIT) ? dks_pkg::POS_LIMIT[dks_pkg::POS_W-1:0] :
                     offs[dks_pkg::POS_W-1:0];
    end

endmodule

### src/dks_min_lane.sv
module dks_min_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step_en,
    input  logic                       read_done,
    input  logic                       win,
    input  logic [dks_pkg::HASH_W-1:0] kmer,
    input  logic [dks_pkg::HASH_W-1:0] seed,
    input  logic [dks_pkg::POS_W-1:0]  pos,
    output logic [dks_pkg::HASH_W-1:0] best_hash_next,
    output logic [dks_pkg::POS_W-1:0]  best_pos_next
);

    logic [dks_pkg::HASH_W-1:0] best_hash_reg;
    logic [dks_pkg::POS_W-1:0]  best_pos_reg;
    logic [dks_pkg::HASH_W-1:0] hash;

    always_comb begin
        hash = kmer ^ seed;
        // strict compare keeps the earliest window on a tie
        if (win && (hash < best_hash_reg)) begin
            best_hash_next = hash;
            best_pos_next  = pos;
        end else begin
            best_hash_next = best_hash_reg;
            best_pos_next  = best_pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_hash_reg <= '1;
            best_pos_reg  <= '0;
        end else if (step_en) begin
            if (read_done) begin
                best_hash_reg <= '1;
                best_pos_reg  <= '0;
            end else begin
                best_hash_reg <= best_hash_next;
                best_pos_reg  <= best_pos_next;
            end
        end
    end

endmodule

### src/dna_kmer_minhash_sketch_unit.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] base_char; tlast = read_end
// m_axis    out  tdata[31:0] min_value, [51:32] min_position, [52] window_seen,
//                [55:53] zero; tuser[1:0] hash_index; tlast = sketch_last
// cfg       in   cfg_index selects the register, cfg_data[31:0] the value
//
// One base per cycle while s_tready is high: the k-mer roll and per-seed compares sit
// between the read state and the lane registers, so a base may follow in the next cycle.
// The last base of a read latches the sketch into a result buffer that drains one
// result a cycle while m_tready is high, from the next cycle on; a further last base
// waits until that buffer is empty.
// Reset (aresetn low, synchronous) clears the read state, the minima and the
// buffer; cfg_ready is always high and writes take effect on the next base.
module dna_kmer_minhash_sketch_unit #(
    parameter int NUM_HASHES = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] base_char
    input  logic                          s_tlast,   // read_end
    // result beats
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,   // min_value, min_position, window_seen
    output logic [dks_pkg::IDX_W-1:0]     m_tuser,   // [1:0] hash_index
    output logic                          m_tlast,   // sketch_last
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dks_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    // lanes beyond the seed registers have no seed, so cap there
    localparam int LANES  = (NUM_HASHES > dks_pkg::SEED_REGS) ? dks_pkg::SEED_REGS :
                            ((NUM_HASHES < 1) ? 1 : NUM_HASHES);
    localparam int LIDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [LIDX_W-1:0] LAST_LANE = LIDX_W'(LANES - 1);

    // configuration registers
    logic [dks_pkg::KLEN_W-1:0] kmer_len_reg;
    logic                       reverse_reg;
    logic [dks_pkg::HASH_W-1:0] seed_reg [dks_pkg::SEED_REGS];

    // per-read state
    logic [dks_pkg::HASH_W-1:0]  kmer_reg;
    logic [dks_pkg::COUNT_W-1:0] base_count_reg;
    logic                        window_any_reg;
    logic                        window_any_next;

    // sketch result buffer
    logic                        snap_busy_reg;
    logic [LIDX_W-1:0]           snap_idx_reg;
    logic                        snap_seen_reg;
    logic [dks_pkg::HASH_W-1:0]  snap_hash_reg [LANES];
    logic [dks_pkg::POS_W-1:0]   snap_pos_reg  [LANES];

    logic                        s_acc;
    logic                        m_acc;
    dks_pkg::kmer_step_t         step;
    logic [dks_pkg::HASH_W-1:0]  lane_hash_next [LANES];
    logic [dks_pkg::POS_W-1:0]   lane_pos_next  [LANES];

    // a read-ending beat needs an empty buffer; other bases always pass
    assign s_tready  = !snap_busy_reg || !s_tlast;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_len_reg <= dks_pkg::KLEN_W'(dks_pkg::KMER_MAX);
            reverse_reg  <= 1'b0;
            for (int j = 0; j < dks_pkg::SEED_REGS; j++) begin
                seed_reg[j] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dks_pkg::REG_KMER_LEN:   kmer_len_reg <= cfg_data[dks_pkg::KLEN_W-1:0];
                dks_pkg::REG_REVERSE:    reverse_reg  <= cfg_data[0];
                dks_pkg::REG_SEED_ZERO:  seed_reg[0]  <= cfg_data;
                dks_pkg::REG_SEED_ONE:   seed_reg[1]  <= cfg_data;
                dks_pkg::REG_SEED_TWO:   seed_reg[2]  <= cfg_data;
                dks_pkg::REG_SEED_THREE: seed_reg[3]  <= cfg_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    dks_kmer_roll u_roll (
        .kmer_cur       (kmer_reg),
        .count_cur      (base_count_reg),
        .kmer_len       (kmer_len_reg),
        .reverse_strand (reverse_reg),
        .base_char      (s_tdata),
        .step           (step)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        dks_min_lane u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .step_en        (s_acc),
            .read_done      (s_tlast),
            .win            (step.win),
            .kmer           (step.kmer),
            .seed           (seed_reg[g]),
            .pos            (step.pos),
            .best_hash_next (lane_hash_next[g]),
            .best_pos_next  (lane_pos_next[g])
        );
    end

    assign window_any_next = window_any_reg || step.win;

    // advance the read state; clear it on the last base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_reg       <= '0;
            base_count_reg <= '0;
            window_any_reg <= 1'b0;
        end else if (s_acc) begin
            if (s_tlast) begin
                kmer_reg       <= '0;
                base_count_reg <= '0;
                window_any_reg <= 1'b0;
            end else begin
                kmer_reg       <= step.kmer;
                base_count_reg <= step.count;
                window_any_reg <= window_any_next;
            end
        end
    end

    // load the buffer on the last base, drain it one result per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_busy_reg <= 1'b0;
            snap_idx_reg  <= '0;
        end else if (s_acc && s_tlast) begin
            snap_busy_reg <= 1'b1;
            snap_idx_reg  <= '0;
        end else if (m_acc) begin
            if (snap_idx_reg == LAST_LANE) begin
                snap_busy_reg <= 1'b0;
            end else begin
                snap_idx_reg <= snap_idx_reg + LIDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_tlast) begin
            snap_seen_reg <= window_any_next;
            for (int j = 0; j < LANES; j++) begin
                snap_hash_reg[j] <= lane_hash_next[j];
                snap_pos_reg[j]  <= lane_pos_next[j];
            end
        end
    end

    assign m_tvalid = snap_busy_reg;
    assign m_tdata  = {3'b000, snap_seen_reg, snap_pos_reg[snap_idx_reg],
                       snap_hash_reg[snap_idx_reg]};
    assign m_tuser  = dks_pkg::IDX_W'(snap_idx_reg);
    assign m_tlast  = (snap_idx_reg == LAST_LANE);

    // a stalled result keeps its lane
    a_hold_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_busy_reg && !m_tready |=> snap_busy_reg && $stable(snap_idx_reg))
        else $error("result lane moved while stalled");

    // a read end starts the sketch at lane zero and clears the base count
    a_read_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> snap_busy_reg && snap_idx_reg == '0 &&
                             base_count_reg == '0)
        else $error("read end did not load the sketch");

    // the final result empties the buffer
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_acc && m_tlast |=> !snap_busy_reg)
        else $error("buffer still busy after last result");

endmodule
